// ===== src/mbrot_pkg.sv =====
// shared types, constants and the saturation helper for the mandelbrot escape-time block
`timescale 1ns / 1ps

package mbrot_pkg;

   // fixed field widths
   localparam int VAL_W      = 32;
   localparam int SAT_IN_W   = 2 * VAL_W;
   localparam int START_W    = 30;
   localparam int COORD_BITS = 11;
   localparam int ITER_BITS  = 16;

   // default fraction width of the fixed-point format
   localparam int FRAC_BITS_DEF = 28;

   // escape bound on |z|^2, in whole units
   localparam int ESC_BOUND = 4;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // saturation limits
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_REAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 3'd5;

   // register reset values
   localparam logic signed [VAL_W-1:0]   STEP_X_RST     = 32'sd469762;
   localparam logic signed [VAL_W-1:0]   ORIGIN_X_RST   = -32'sd671088640;
   localparam logic signed [VAL_W-1:0]   STEP_Y_RST     = 32'sd524288;
   localparam logic signed [VAL_W-1:0]   ORIGIN_Y_RST   = -32'sd268435456;
   localparam logic signed [START_W-1:0] START_REAL_RST = -30'sd268435456;
   localparam logic [ITER_BITS-1:0]      MAX_ITER_RST   = 16'd256;

   // input transaction
   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic [ITER_BITS-1:0]  iter_count;
      logic                  escaped;
   } rsp_type;

   // pixel with its mapped point, held between front and back
   typedef struct packed {
      logic [COORD_BITS-1:0]     px;
      logic [COORD_BITS-1:0]     py;
      logic signed [VAL_W-1:0]   cr;
      logic signed [VAL_W-1:0]   ci;
   } job_type;

   // coordinate mapping settings
   typedef struct packed {
      logic signed [VAL_W-1:0] step_x;
      logic signed [VAL_W-1:0] origin_x;
      logic signed [VAL_W-1:0] step_y;
      logic signed [VAL_W-1:0] origin_y;
   } map_cfg_type;

   // iteration settings
   typedef struct packed {
      logic signed [START_W-1:0] start_real;
      logic [ITER_BITS-1:0]      max_iter;
   } iter_cfg_type;

   // clamp a wide signed value to the value range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = {{(SAT_IN_W-VAL_W){1'b0}}, VAL_MAX};
      lo = {{(SAT_IN_W-VAL_W){1'b1}}, VAL_MIN};
      if (v > hi) begin
         return VAL_MAX;
      end else if (v < lo) begin
         return VAL_MIN;
      end else begin
         return v[VAL_W-1:0];
      end
   endfunction

endpackage

// ===== src/mbrot_front.sv =====
// front end: accepts pixels and maps them to points of the complex plane
`timescale 1ns / 1ps

module mbrot_front (
   input  logic                  clock,
   input  logic                  reset,
   input  mbrot_pkg::map_cfg_type cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mbrot_pkg::req_type    req_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output mbrot_pkg::job_type    push_data
);
   import mbrot_pkg::*;

   localparam int MAP_W = COORD_BITS + 1 + VAL_W;
   localparam int SUM_W = MAP_W + 1;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [COORD_BITS-1:0]   s1_px_ff;
   logic [COORD_BITS-1:0]   s1_px_in;
   logic [COORD_BITS-1:0]   s1_py_ff;
   logic [COORD_BITS-1:0]   s1_py_in;
   logic signed [MAP_W-1:0] s1_prod_x_ff;
   logic signed [MAP_W-1:0] s1_prod_x_in;
   logic signed [MAP_W-1:0] s1_prod_y_ff;
   logic signed [MAP_W-1:0] s1_prod_y_in;
   logic                    advance;
   logic signed [SUM_W-1:0] cr_sum;
   logic signed [SUM_W-1:0] ci_sum;

   // stage moves when empty or when the queue takes its transaction
   assign advance   = !s1_valid_ff || push_ready;
   assign req_stall = !advance;

   // pixel times step products
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_px_in     = s1_px_ff;
      s1_py_in     = s1_py_ff;
      s1_prod_x_in = s1_prod_x_ff;
      s1_prod_y_in = s1_prod_y_ff;
      if (advance) begin
         s1_valid_in  = req_valid;
         s1_px_in     = req_data.pixel_x;
         s1_py_in     = req_data.pixel_y;
         s1_prod_x_in = $signed({1'b0, req_data.pixel_x}) * cfg.step_x;
         s1_prod_y_in = $signed({1'b0, req_data.pixel_y}) * cfg.step_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_px_ff     <= s1_px_in;
      s1_py_ff     <= s1_py_in;
      s1_prod_x_ff <= s1_prod_x_in;
      s1_prod_y_ff <= s1_prod_y_in;
   end

   // add origin and clamp
   assign cr_sum = SUM_W'(s1_prod_x_ff) + SUM_W'(cfg.origin_x);
   assign ci_sum = SUM_W'(s1_prod_y_ff) + SUM_W'(cfg.origin_y);

   assign push_valid   = s1_valid_ff;
   assign push_data.px = s1_px_ff;
   assign push_data.py = s1_py_ff;
   assign push_data.cr = sat_val(SAT_IN_W'(cr_sum));
   assign push_data.ci = sat_val(SAT_IN_W'(ci_sum));

endmodule

// ===== src/mbrot_queue.sv =====
// short queue of mapped pixels between front and back
`timescale 1ns / 1ps

module mbrot_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mbrot_pkg::job_type push_data,
   output logic               pop_valid,
   input  logic               pop,
   output mbrot_pkg::job_type pop_data
);
   import mbrot_pkg::*;

   localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QADDR_W-1:0] LAST_SLOT = QADDR_W'(QUEUE_DEPTH - 1);

   job_type            slots_ff [QUEUE_DEPTH];
   logic [QADDR_W-1:0] wr_ptr_ff;
   logic [QADDR_W-1:0] wr_ptr_in;
   logic [QADDR_W-1:0] rd_ptr_ff;
   logic [QADDR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/mbrot_engine.sv =====
// back end: runs the z = z*z + c recurrence for one pixel and holds the result
`timescale 1ns / 1ps

module mbrot_engine #(
   parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbrot_pkg::iter_cfg_type cfg,
   input  logic                    job_valid,
   input  mbrot_pkg::job_type      job_data,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mbrot_pkg::rsp_type      rsp_data
);
   import mbrot_pkg::*;

   localparam int PROD_W = 2 * VAL_W;
   localparam int SQ_W   = PROD_W - FRAC_BITS;
   localparam int RI_W   = SQ_W + 1;
   localparam int NEW_W  = ((RI_W > VAL_W) ? RI_W : VAL_W) + 2;
   localparam int CMP_W  = ((SQ_W + 1) > (FRAC_BITS + 3)) ? (SQ_W + 1) : (FRAC_BITS + 3);
   localparam logic [CMP_W-1:0] BOUND = CMP_W'(ESC_BOUND) << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic [COORD_BITS-1:0]    px_ff;
   logic [COORD_BITS-1:0]    px_in;
   logic [COORD_BITS-1:0]    py_ff;
   logic [COORD_BITS-1:0]    py_in;
   logic signed [VAL_W-1:0]  cr_ff;
   logic signed [VAL_W-1:0]  cr_in;
   logic signed [VAL_W-1:0]  ci_ff;
   logic signed [VAL_W-1:0]  ci_in;
   logic signed [VAL_W-1:0]  zr_ff;
   logic signed [VAL_W-1:0]  zr_in;
   logic signed [VAL_W-1:0]  zi_ff;
   logic signed [VAL_W-1:0]  zi_in;
   logic [ITER_BITS-1:0]     n_ff;
   logic [ITER_BITS-1:0]     n_in;
   logic                     esc_ff;
   logic                     esc_in;
   logic signed [PROD_W-1:0] p_rr_ff;
   logic signed [PROD_W-1:0] p_rr_in;
   logic signed [PROD_W-1:0] p_ii_ff;
   logic signed [PROD_W-1:0] p_ii_in;
   logic signed [PROD_W-1:0] p_ri_ff;
   logic signed [PROD_W-1:0] p_ri_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;

   logic [SQ_W-1:0]          rr_u;
   logic [SQ_W-1:0]          ii_u;
   logic signed [RI_W-1:0]   ri_s;
   logic [CMP_W-1:0]         mag;
   logic                     escape_hit;
   logic                     limit_hit;
   logic signed [NEW_W-1:0]  zr_sum;
   logic signed [NEW_W-1:0]  zi_sum;
   logic                     out_free;

   // shifted products, floor rounding by taking the upper bits
   assign rr_u = p_rr_ff[PROD_W-1:FRAC_BITS];
   assign ii_u = p_ii_ff[PROD_W-1:FRAC_BITS];
   assign ri_s = p_ri_ff[PROD_W-1:FRAC_BITS-1];

   // escape and limit tests on the current z
   assign mag        = CMP_W'(rr_u) + CMP_W'(ii_u);
   assign escape_hit = mag > BOUND;
   assign limit_hit  = n_ff >= cfg.max_iter;

   // next z before clamping
   assign zr_sum = NEW_W'($signed(rr_u)) - NEW_W'($signed(ii_u)) + NEW_W'(cr_ff);
   assign zi_sum = NEW_W'(ri_s) + NEW_W'(ci_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: load, multiply, update, hand over
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      n_in         = n_ff;
      esc_in       = esc_ff;
      p_rr_in      = p_rr_ff;
      p_ii_in      = p_ii_ff;
      p_ri_in      = p_ri_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               px_in    = job_data.px;
               py_in    = job_data.py;
               cr_in    = job_data.cr;
               ci_in    = job_data.ci;
               zr_in    = VAL_W'(cfg.start_real);
               zi_in    = '0;
               n_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p_rr_in  = zr_ff * zr_ff;
            p_ii_in  = zi_ff * zi_ff;
            p_ri_in  = zr_ff * zi_ff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (escape_hit || limit_hit) begin
               esc_in   = !limit_hit;
               state_in = ST_DONE;
            end else begin
               zr_in    = sat_val(SAT_IN_W'(zr_sum));
               zi_in    = sat_val(SAT_IN_W'(zi_sum));
               n_in     = n_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_x      = px_ff;
               rsp_data_in.out_y      = py_ff;
               rsp_data_in.iter_count = esc_ff ? n_ff : '0;
               rsp_data_in.escaped    = esc_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      n_ff        <= n_in;
      esc_ff      <= esc_in;
      p_rr_ff     <= p_rr_in;
      p_ii_ff     <= p_ii_in;
      p_ri_ff     <= p_ri_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// top level of the mandelbrot escape-time block: register file, front, queue and back
`timescale 1ns / 1ps

// Usage
//   req_*: one pixel (column, row) per transaction, taken when req_valid is high
//   and req_stall is low. rsp_*: one result per pixel, in input order, with the
//   coordinates passed through, the iteration count and the escape flag.
//   csr_*: register writes by index; csr_ready is always high. Writes must be made
//   only while no pixel is in flight; the block itself does not enforce this.
// Sequencing
//   in the back end, each of a pixel's n iterations is a multiply state followed
//   by an update state, between a load state and a hand-over state. The back end
//   takes a new pixel only after handing over the last one, so throughput is
//   bounded by the single shared iteration unit (n at most max_iter).
// Flow control
//   the front holds one pixel and the queue two more, so up to three pixels are
//   taken while the back end works or while a result waits under rsp_stall.
//   A stalled result holds still and stops the back end only at hand-over.
// Reset
//   synchronous, active high: the settings registers return to their defaults and
//   the valid flags, queue count and sequencer clear, so the pipeline empties; no clearing pass is needed.

module mandelbrot_escape_time #(
   parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mbrot_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mbrot_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbrot_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbrot_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mbrot_pkg::*;

   logic signed [VAL_W-1:0]   step_x_ff;
   logic signed [VAL_W-1:0]   origin_x_ff;
   logic signed [VAL_W-1:0]   step_y_ff;
   logic signed [VAL_W-1:0]   origin_y_ff;
   logic signed [START_W-1:0] start_real_ff;
   logic [ITER_BITS-1:0]      max_iter_ff;
   map_cfg_type               map_cfg;
   iter_cfg_type              iter_cfg;
   logic                      push_valid;
   logic                      push_ready;
   job_type                   push_data;
   logic                      pop_valid;
   logic                      pop;
   job_type                   pop_data;

   assign csr_ready = 1'b1;

   // register file, unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff     <= STEP_X_RST;
         origin_x_ff   <= ORIGIN_X_RST;
         step_y_ff     <= STEP_Y_RST;
         origin_y_ff   <= ORIGIN_Y_RST;
         start_real_ff <= START_REAL_RST;
         max_iter_ff   <= MAX_ITER_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_X:     step_x_ff     <= csr_wdata[VAL_W-1:0];
            CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata[VAL_W-1:0];
            CSR_STEP_Y:     step_y_ff     <= csr_wdata[VAL_W-1:0];
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata[VAL_W-1:0];
            CSR_START_REAL: start_real_ff <= csr_wdata[START_W-1:0];
            CSR_MAX_ITER:   max_iter_ff   <= csr_wdata[ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // settings bundles
   assign map_cfg.step_x      = step_x_ff;
   assign map_cfg.origin_x    = origin_x_ff;
   assign map_cfg.step_y      = step_y_ff;
   assign map_cfg.origin_y    = origin_y_ff;
   assign iter_cfg.start_real = start_real_ff;
   assign iter_cfg.max_iter   = max_iter_ff;

   // coordinate mapping
   mbrot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (map_cfg),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   mbrot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // iteration unit and result register
   mbrot_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (iter_cfg),
      .job_valid (pop_valid),
      .job_data  (pop_data),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/mbrot_checker.sv =====
// transaction checker for the mandelbrot escape-time block: predicts each result and compares
`timescale 1ns / 1ps

module mbrot_checker #(
   parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  mbrot_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  mbrot_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mbrot_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbrot_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatch_count,
   output int                               results_due
);
   import mbrot_pkg::*;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // own copy of the register file
   logic signed [VAL_W-1:0]   col_step;
   logic signed [VAL_W-1:0]   col_base;
   logic signed [VAL_W-1:0]   row_step;
   logic signed [VAL_W-1:0]   row_base;
   logic signed [START_W-1:0] z0_real;
   logic [ITER_BITS-1:0]      iter_limit;

   rsp_type pending_results[$];
   rsp_type want;
   int      mismatches = 0;

   // clamp to the signed 32-bit value range
   function automatic longint clamp_q(input longint v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end else if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v;
   endfunction

   // map the pixel to c and count iterations of z*z + c until |z|^2 leaves 4 or the limit
   function automatic rsp_type escape_result(input req_type pix);
      longint  cr;
      longint  ci;
      longint  zr;
      longint  zi;
      longint  rr;
      longint  ii;
      longint  ri;
      longint  bound;
      int      n;
      rsp_type r;
      cr    = clamp_q(longint'(col_base) + longint'(pix.pixel_x) * longint'(col_step));
      ci    = clamp_q(longint'(row_base) + longint'(pix.pixel_y) * longint'(row_step));
      zr    = longint'(z0_real);
      zi    = 0;
      bound = longint'(ESC_BOUND) <<< FRAC_BITS;
      n     = 0;
      rr    = (zr * zr) >>> FRAC_BITS;
      ii    = (zi * zi) >>> FRAC_BITS;
      while (rr + ii <= bound && n < int'(iter_limit)) begin
         ri = (zr * zi) >>> (FRAC_BITS - 1);
         zr = clamp_q(rr - ii + cr);
         zi = clamp_q(ri + ci);
         n++;
         rr = (zr * zr) >>> FRAC_BITS;
         ii = (zi * zi) >>> FRAC_BITS;
      end
      r.out_x      = pix.pixel_x;
      r.out_y      = pix.pixel_y;
      r.escaped    = (n < int'(iter_limit));
      r.iter_count = r.escaped ? n[ITER_BITS-1:0] : '0;
      return r;
   endfunction

   // count and report a field mismatch
   task automatic report(input string field, input longint want_v, input longint got_v);
      mismatches++;
      $error("%s: expected %0d, got %0d (pixel %0d,%0d)", field, want_v, got_v,
             want.out_x, want.out_y);
   endtask

   // watch the three channels
   always @(posedge clock) begin
      if (reset) begin
         col_step   = STEP_X_RST;
         col_base   = ORIGIN_X_RST;
         row_step   = STEP_Y_RST;
         row_base   = ORIGIN_Y_RST;
         z0_real    = START_REAL_RST;
         iter_limit = MAX_ITER_RST;
         pending_results.delete();
      end else begin
         // register writes, unknown indexes ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_X:     col_step   = csr_wdata;
               CSR_ORIGIN_X:   col_base   = csr_wdata;
               CSR_STEP_Y:     row_step   = csr_wdata;
               CSR_ORIGIN_Y:   row_base   = csr_wdata;
               CSR_START_REAL: z0_real    = csr_wdata[START_W-1:0];
               CSR_MAX_ITER:   iter_limit = csr_wdata[ITER_BITS-1:0];
               default: ;
            endcase
         end
         // result transaction against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $error("unexpected result for pixel %0d,%0d", rsp_data.out_x, rsp_data.out_y);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.out_x !== want.out_x) begin
                  report("out_x", want.out_x, rsp_data.out_x);
               end
               if (rsp_data.out_y !== want.out_y) begin
                  report("out_y", want.out_y, rsp_data.out_y);
               end
               if (rsp_data.iter_count !== want.iter_count) begin
                  report("iter_count", want.iter_count, rsp_data.iter_count);
               end
               if (rsp_data.escaped !== want.escaped) begin
                  report("escaped", want.escaped, rsp_data.escaped);
               end
            end
         end
         // accepted pixel
         if (req_valid && !req_stall) begin
            pending_results.push_back(escape_result(req_data));
         end
      end
      results_due    <= pending_results.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== test/tb_mandelbrot_escape_time.sv =====
// testbench top for the mandelbrot escape-time block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

   import mbrot_pkg::*;

   // indexes past the register file, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   // handy Q4.28 patterns
   localparam logic [31:0] START_LOW  = 32'h2000_0000;   // most negative 30-bit start
   localparam logic [31:0] START_HIGH = 32'h1FFF_FFFF;   // most positive 30-bit start
   localparam logic [31:0] QUARTER    = 32'h0400_0000;   // 0.25, cusp of the cardioid
   localparam logic [31:0] ITER_CEIL  = 32'h0000_FFFF;
   localparam int          PHASES     = 32;
   localparam int          PHASE_LEN  = 50;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int      mismatch_count;
   int      results_due;
   bit      pace_on;

   mandelbrot_escape_time #(
      .FRAC_BITS (FRAC_BITS_DEF)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mbrot_checker #(
      .FRAC_BITS (FRAC_BITS_DEF)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #50_000_000;
      $display("FAIL mandelbrot_escape_time");
      $finish;
   end

   // result side: random stall before each result
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = pace_on ? $urandom_range(0, 13) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // one pixel transaction after a random gap
   task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
      int gap;
      gap = pace_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel_x: px, pixel_y: py};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // one register write, valid left high for back-to-back writes
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // reprogram the whole view once the block is idle
   task automatic load_view(input logic [31:0] sx, input logic [31:0] ox,
                            input logic [31:0] sy, input logic [31:0] oy,
                            input logic [31:0] sr, input logic [31:0] mi);
      wait_drained();
      csr_put(CSR_STEP_X, sx);
      csr_put(CSR_ORIGIN_X, ox);
      csr_put(CSR_SPARE_A, $urandom());
      csr_put(CSR_STEP_Y, sy);
      csr_put(CSR_ORIGIN_Y, oy);
      csr_put(CSR_START_REAL, sr);
      csr_put(CSR_MAX_ITER, mi);
      csr_put(CSR_SPARE_B, $urandom());
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      int          ph;
      int          zoom;
      logic [31:0] sx;
      logic [31:0] ox;
      logic [31:0] sy;
      logic [31:0] oy;
      logic [31:0] sr;
      logic [31:0] mi;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pace_on   = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset view: corners, alternating bits, a cardioid point and c near zero
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);
      send_pixel(11'd0, 11'd2047);
      send_pixel(11'd2047, 11'd0);
      send_pixel(11'd1365, 11'd682);
      send_pixel(11'd682, 11'd1365);
      send_pixel(11'd1024, 11'd512);
      send_pixel(11'd1430, 11'd512);

      // zero limit: nothing iterates
      load_view('0, '0, '0, '0, '0, '0);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);

      // saturated c, most negative start, single iteration
      load_view(VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, START_LOW, 32'd1);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);
      send_pixel(11'd1, 11'd0);

      // opposite extremes, most positive start
      load_view(VAL_MIN, '0, VAL_MAX, '0, START_HIGH, 32'd8);
      send_pixel(11'd2047, 11'd0);
      send_pixel(11'd0, 11'd2047);
      send_pixel(11'd3, 11'd5);

      // largest limit: c at zero never escapes
      load_view('0, '0, '0, '0, '0, ITER_CEIL);
      send_pixel(11'd5, 11'd9);

      // just right of the cusp: slow escape with a large count
      load_view('0, QUARTER + 32'd16, '0, '0, '0, ITER_CEIL);
      send_pixel(11'd0, 11'd0);

      // random views, mostly near the set at assorted zoom levels
      for (ph = 0; ph < PHASES; ph++) begin
         pace_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            sx = $urandom();
            ox = $urandom();
            sy = $urandom();
            oy = $urandom();
            sr = $urandom();
            mi = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 64);
         end else begin
            zoom = $urandom_range(0, 12);
            sx = ($urandom() & 32'h000F_FFFF) >> zoom;
            sy = ($urandom() & 32'h000F_FFFF) >> zoom;
            if ($urandom_range(0, 1) == 1) begin
               sx = -sx;
            end
            if ($urandom_range(0, 1) == 1) begin
               sy = -sy;
            end
            ox = $urandom_range(0, 939524096) - 32'd671088640;
            oy = $urandom_range(0, 805306368) - 32'd402653184;
            sr = ($urandom_range(0, 7) == 0) ? $urandom()
                                             : $urandom_range(0, 536870912) - 32'd268435456;
            mi = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 48) : $urandom_range(49, 160);
            mi = mi | ($urandom() & 32'hFFFF_0000);
         end
         load_view(sx, ox, sy, oy, sr, mi);
         repeat (PHASE_LEN) begin
            send_pixel(COORD_BITS'($urandom_range(0, 2047)), COORD_BITS'($urandom_range(0, 2047)));
         end
      end

      // drain, then allow for a stray late result
      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS mandelbrot_escape_time");
      end else begin
         $display("FAIL mandelbrot_escape_time");
      end
      $finish;
   end

endmodule
